// ===== hw/rtl/agms_pkg.sv =====
// Shared codes, constants and phase tables for the arm grab motion sequencer.
package agms_pkg;

    localparam int ANGLE_W = 16;
    localparam int TOL_W   = 10;
    localparam int CNT_W   = 16;
    localparam int CUR_W   = 15;
    localparam int PHASE_W = 4;
    localparam int FUNC_W  = 2;
    localparam int FAULT_W = 2;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 24;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ESTOP = 2'd2;

    localparam logic [FAULT_W-1:0] FAULT_NONE    = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_REFUSED = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_ABORTED = 2'd2;

    localparam logic [CIDX_W-1:0] REG_HOME_ANGLE      = 3'd0;
    localparam logic [CIDX_W-1:0] REG_START_TOLERANCE = 3'd1;
    localparam logic [CIDX_W-1:0] REG_HOME_TOLERANCE  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd3;
    localparam logic [CIDX_W-1:0] REG_HOLD_TICKS      = 3'd4;

    localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
    localparam logic [PHASE_W-1:0] PH_HOME_CHECK = 4'd1;
    localparam logic [PHASE_W-1:0] PH_DESCEND    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_COAST      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_BRAKE      = 4'd4;
    localparam logic [PHASE_W-1:0] PH_SETTLE     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CLAMP      = 4'd6;
    localparam logic [PHASE_W-1:0] PH_LIFT       = 4'd7;
    localparam logic [PHASE_W-1:0] PH_LIFT_COAST = 4'd8;
    localparam logic [PHASE_W-1:0] PH_TOP_HOLD   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_RETURN     = 4'd10;
    localparam logic [PHASE_W-1:0] PH_LAST       = 4'd10;

    localparam logic signed [CUR_W-1:0] CUR_ZERO    = 15'sd0;
    localparam logic signed [CUR_W-1:0] CUR_DESCEND = -15'sd2000;
    localparam logic signed [CUR_W-1:0] CUR_BRAKE   = 15'sd800;
    localparam logic signed [CUR_W-1:0] CUR_LIFT    = 15'sd10000;
    localparam logic signed [CUR_W-1:0] CUR_RETURN  = -15'sd8000;

    localparam logic signed [ANGLE_W-1:0] TH_DESCEND    = -16'sd65;
    localparam logic signed [ANGLE_W-1:0] TH_COAST      = -16'sd95;
    localparam logic signed [ANGLE_W-1:0] TH_BRAKE      = -16'sd150;
    localparam logic signed [ANGLE_W-1:0] TH_LIFT       = -16'sd67;
    localparam logic signed [ANGLE_W-1:0] TH_LIFT_COAST = -16'sd40;
    localparam logic signed [ANGLE_W-1:0] TH_RETURN     = -16'sd65;

    localparam logic signed [ANGLE_W-1:0] HOME_ANGLE_RST      = 16'sd0;
    localparam logic [TOL_W-1:0]          START_TOLERANCE_RST = 10'd100;
    localparam logic [TOL_W-1:0]          HOME_TOLERANCE_RST  = 10'd5;
    localparam logic [CNT_W-1:0]          SAMPLE_INTERVAL_RST = 16'd10;
    localparam logic [CNT_W-1:0]          HOLD_TICKS_RST      = 16'd2000;

    typedef struct packed {
        logic [PHASE_W-1:0]      phase;
        logic signed [CUR_W-1:0] target;
        logic                    set_target;
        logic                    strobe;
        logic                    clamp_set;
        logic                    clamp_clr;
        logic                    hold_clr;
        logic                    int_clr;
    } enter_t;

    function automatic logic is_motion(input logic [PHASE_W-1:0] p);
        logic r;
        case (p)
            PH_DESCEND, PH_COAST, PH_BRAKE, PH_LIFT, PH_LIFT_COAST, PH_RETURN: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic signed [CUR_W-1:0] motion_current(input logic [PHASE_W-1:0] p);
        logic signed [CUR_W-1:0] r;
        case (p)
            PH_DESCEND: r = CUR_DESCEND;
            PH_BRAKE:   r = CUR_BRAKE;
            PH_LIFT:    r = CUR_LIFT;
            PH_RETURN:  r = CUR_RETURN;
            default:    r = CUR_ZERO;
        endcase
        return r;
    endfunction

    function automatic logic motion_cond(input logic [PHASE_W-1:0] p,
                                         input logic signed [ANGLE_W-1:0] a);
        logic r;
        case (p)
            PH_DESCEND:    r = a > TH_DESCEND;
            PH_COAST:      r = a > TH_COAST;
            PH_BRAKE:      r = a > TH_BRAKE;
            PH_LIFT:       r = a < TH_LIFT;
            PH_LIFT_COAST: r = a < TH_LIFT_COAST;
            PH_RETURN:     r = a > TH_RETURN;
            default:       r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/arm_grab_motion_sequencer.sv =====
// Top level of the arm grab motion sequencer: request handshakes, state and result register.
//
// Usage:
//   Input requests arrive on s_tvalid/s_tready; s_tuser carries the function code
//   (tick, start, emergency stop) and s_tdata the measured motor angle.
//   One result leaves per request on m_tvalid/m_tready, m_tdata carrying drive
//   current, send strobe, clamp state, running flag, phase and fault.
//   Configuration registers are written on cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write them only while no request is in flight.
// Path: a taken request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while m_tready is high; the whole sequencing step for a request is one
//   pass through the phase compare chain between the input and result registers.
// Stall: when m_tready is low the result holds, one more request sits in the input
//   register, and s_tready then drops until the result is taken.
// Reset: aresetn low at an edge clears both valid flags, returns the sequence to idle
//   with zero drive and relaxed clamp, and restores the configuration defaults.
module arm_grab_motion_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // motor_angle[15:0]
    input  logic [agms_pkg::IN_W-1:0]     s_tdata,
    // func[1:0]
    input  logic [agms_pkg::FUNC_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // drive_current[14:0], send_strobe[15], clamp_closed[16], running[17],
    // current_phase[21:18], fault[23:22]
    output logic [agms_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [agms_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [agms_pkg::CDATA_W-1:0]  cfg_data
);

    logic                                   in_valid_reg, in_valid_next;
    logic [agms_pkg::FUNC_W-1:0]            func_reg;
    logic signed [agms_pkg::ANGLE_W-1:0]    angle_reg;
    logic                                   out_valid_reg, out_valid_next;
    logic [agms_pkg::OUT_W-1:0]             out_data_reg, out_data_next;

    logic signed [agms_pkg::ANGLE_W-1:0]    home_angle_reg;
    logic [agms_pkg::TOL_W-1:0]             start_tol_reg;
    logic [agms_pkg::TOL_W-1:0]             home_tol_reg;
    logic [agms_pkg::CNT_W-1:0]             interval_ticks_reg;
    logic [agms_pkg::CNT_W-1:0]             hold_ticks_reg;

    logic [agms_pkg::PHASE_W-1:0]           phase_reg, phase_next;
    logic [agms_pkg::CNT_W-1:0]             interval_count_reg, interval_count_next;
    logic [agms_pkg::CNT_W-1:0]             hold_count_reg, hold_count_next;
    logic signed [agms_pkg::CUR_W-1:0]      target_reg, target_next;
    logic                                   clamp_reg, clamp_next;

    logic                                   s_accept;
    logic                                   proc;
    logic                                   cfg_write;

    logic signed [agms_pkg::ANGLE_W:0]      diff;
    logic [agms_pkg::ANGLE_W:0]             abs_diff;
    logic [agms_pkg::CNT_W-1:0]             ival;
    logic [agms_pkg::CNT_W-1:0]             hval;
    logic [agms_pkg::CNT_W:0]               interval_inc;
    logic [agms_pkg::CNT_W:0]               hold_inc;
    logic [agms_pkg::PHASE_W-1:0]           enter_from;
    agms_pkg::enter_t                       ent;

    function automatic agms_pkg::enter_t enter_phase(
        input logic [agms_pkg::PHASE_W-1:0]        p_in,
        input logic signed [agms_pkg::ANGLE_W-1:0] a
    );
        agms_pkg::enter_t             r;
        logic [agms_pkg::PHASE_W-1:0] p;
        logic                         done;
        r            = '0;
        r.phase      = p_in;
        r.target     = agms_pkg::CUR_ZERO;
        p            = p_in;
        done         = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (!done) begin
                if (p > agms_pkg::PH_LAST) begin
                    r.clamp_clr  = 1'b1;
                    r.set_target = 1'b1;
                    r.target     = agms_pkg::CUR_ZERO;
                    r.strobe     = 1'b1;
                    r.phase      = agms_pkg::PH_IDLE;
                    done         = 1'b1;
                end else if (agms_pkg::is_motion(p)) begin
                    if (agms_pkg::motion_cond(p, a)) begin
                        r.set_target = 1'b1;
                        r.target     = agms_pkg::motion_current(p);
                        r.strobe     = 1'b1;
                        r.phase      = p;
                        r.int_clr    = 1'b1;
                        done         = 1'b1;
                    end else begin
                        p = p + 4'd1;
                    end
                end else begin
                    if (p == agms_pkg::PH_CLAMP) begin
                        r.clamp_set = 1'b1;
                    end else begin
                        r.set_target = 1'b1;
                        r.target     = agms_pkg::CUR_ZERO;
                        r.strobe     = 1'b1;
                    end
                    r.phase    = p;
                    r.hold_clr = 1'b1;
                    done       = 1'b1;
                end
            end
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign proc      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign diff     = {angle_reg[agms_pkg::ANGLE_W-1], angle_reg}
                    - {home_angle_reg[agms_pkg::ANGLE_W-1], home_angle_reg};
    assign abs_diff = diff[agms_pkg::ANGLE_W] ? (~diff + 17'sd1) : diff;

    assign ival         = (interval_ticks_reg == '0) ? 16'd1 : interval_ticks_reg;
    assign hval         = (hold_ticks_reg == '0) ? 16'd1 : hold_ticks_reg;
    assign interval_inc = {1'b0, interval_count_reg} + 17'd1;
    assign hold_inc     = {1'b0, hold_count_reg} + 17'd1;
    assign enter_from   = (phase_reg == agms_pkg::PH_HOME_CHECK) ? agms_pkg::PH_DESCEND
                                                                 : phase_reg + 4'd1;
    assign ent          = enter_phase(enter_from, angle_reg);

    always_comb begin
        logic                          strobe;
        logic                          do_enter;
        logic [agms_pkg::FAULT_W-1:0]  fault;
        phase_next          = phase_reg;
        interval_count_next = interval_count_reg;
        hold_count_next     = hold_count_reg;
        target_next         = target_reg;
        clamp_next          = clamp_reg;
        strobe              = 1'b0;
        do_enter            = 1'b0;
        fault               = agms_pkg::FAULT_NONE;
        case (func_reg)
            agms_pkg::FUNC_START: begin
                if (phase_reg == agms_pkg::PH_IDLE &&
                    abs_diff <= {7'd0, start_tol_reg}) begin
                    phase_next = agms_pkg::PH_HOME_CHECK;
                end else begin
                    fault = agms_pkg::FAULT_REFUSED;
                end
            end
            agms_pkg::FUNC_ESTOP: begin
                target_next = agms_pkg::CUR_ZERO;
                strobe      = 1'b1;
                phase_next  = agms_pkg::PH_IDLE;
            end
            agms_pkg::FUNC_TICK: begin
                if (phase_reg == agms_pkg::PH_HOME_CHECK) begin
                    if (abs_diff <= {7'd0, home_tol_reg}) begin
                        do_enter = 1'b1;
                    end else begin
                        target_next = agms_pkg::CUR_ZERO;
                        strobe      = 1'b1;
                        phase_next  = agms_pkg::PH_IDLE;
                        fault       = agms_pkg::FAULT_ABORTED;
                    end
                end else if (agms_pkg::is_motion(phase_reg)) begin
                    if (interval_inc >= {1'b0, ival}) begin
                        interval_count_next = '0;
                        if (agms_pkg::motion_cond(phase_reg, angle_reg)) begin
                            strobe = 1'b1;
                        end else begin
                            do_enter = 1'b1;
                        end
                    end else begin
                        interval_count_next = interval_inc[agms_pkg::CNT_W-1:0];
                    end
                end else if (phase_reg != agms_pkg::PH_IDLE) begin
                    if (hold_inc >= {1'b0, hval}) begin
                        hold_count_next = hold_inc[agms_pkg::CNT_W-1:0];
                        do_enter        = 1'b1;
                    end else begin
                        hold_count_next = hold_inc[agms_pkg::CNT_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        if (do_enter) begin
            phase_next = ent.phase;
            if (ent.set_target) begin
                target_next = ent.target;
            end
            if (ent.strobe) begin
                strobe = 1'b1;
            end
            if (ent.clamp_set) begin
                clamp_next = 1'b1;
            end
            if (ent.clamp_clr) begin
                clamp_next = 1'b0;
            end
            if (ent.hold_clr) begin
                hold_count_next = '0;
            end
            if (ent.int_clr) begin
                interval_count_next = '0;
            end
        end
        out_data_next = {fault, phase_next, (phase_next != agms_pkg::PH_IDLE),
                         clamp_next, strobe, target_next};
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= agms_pkg::PH_IDLE;
            interval_count_reg <= '0;
            hold_count_reg     <= '0;
            target_reg         <= agms_pkg::CUR_ZERO;
            clamp_reg          <= 1'b0;
            home_angle_reg     <= agms_pkg::HOME_ANGLE_RST;
            start_tol_reg      <= agms_pkg::START_TOLERANCE_RST;
            home_tol_reg       <= agms_pkg::HOME_TOLERANCE_RST;
            interval_ticks_reg <= agms_pkg::SAMPLE_INTERVAL_RST;
            hold_ticks_reg     <= agms_pkg::HOLD_TICKS_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc) begin
                phase_reg          <= phase_next;
                interval_count_reg <= interval_count_next;
                hold_count_reg     <= hold_count_next;
                target_reg         <= target_next;
                clamp_reg          <= clamp_next;
            end
            if (cfg_write) begin
                case (cfg_index)
                    agms_pkg::REG_HOME_ANGLE:      home_angle_reg     <= cfg_data;
                    agms_pkg::REG_START_TOLERANCE: start_tol_reg      <= cfg_data[agms_pkg::TOL_W-1:0];
                    agms_pkg::REG_HOME_TOLERANCE:  home_tol_reg       <= cfg_data[agms_pkg::TOL_W-1:0];
                    agms_pkg::REG_SAMPLE_INTERVAL: interval_ticks_reg <= cfg_data;
                    agms_pkg::REG_HOLD_TICKS:      hold_ticks_reg     <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg  <= s_tuser;
            angle_reg <= s_tdata;
        end
        if (proc) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== hw/rtl/agms_checker.sv =====
// Port-level checker for the arm grab motion sequencer, bound to the top level.
module agms_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [agms_pkg::OUT_W-1:0]   m_tdata
);

    logic [agms_pkg::PHASE_W-1:0] phase_f;
    logic [agms_pkg::FAULT_W-1:0] fault_f;

    assign phase_f = m_tdata[21:18];
    assign fault_f = m_tdata[23:22];

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_running_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[17] == (phase_f != agms_pkg::PH_IDLE))
        else $error("running flag disagrees with phase");

    a_codes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> phase_f <= agms_pkg::PH_LAST && fault_f <= agms_pkg::FAULT_ABORTED)
        else $error("phase or fault code out of range");

    a_abort_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && fault_f == agms_pkg::FAULT_ABORTED |->
            m_tdata[15] && !m_tdata[17] && m_tdata[14:0] == '0)
        else $error("abort did not zero and send the drive");

endmodule

bind arm_grab_motion_sequencer agms_checker u_agms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
